FILE: rtl/low_battery_trimmed_mean_monitor_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the low-battery trimmed-mean monitor
// Shared immediate-style wrappers around concurrent assertions on clk / rst.
// ----------------------------------------------------------------------------
`ifndef LOW_BATTERY_TRIMMED_MEAN_MONITOR_DEFINES_SVH
`define LOW_BATTERY_TRIMMED_MEAN_MONITOR_DEFINES_SVH

// Same-cycle implication, idle during reset
`define LBTM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle during reset
`define LBTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lbtm_pkg.sv
// ----------------------------------------------------------------------------
// lbtm_pkg
// Widths, register indexes, reset values and shared types of the monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package lbtm_pkg;

  localparam int LEVEL_W    = 12;
  localparam int SUM_W      = 16;
  localparam int POS_W      = 4;
  localparam int CNT_W      = 5;
  localparam int LIMIT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 2'd1;

  // Register reset values
  localparam logic [LEVEL_W-1:0] RESET_THRESHOLD = 12'd2771;
  localparam logic [LIMIT_W-1:0] RESET_RETRY     = 4'd3;

  // Low-window counter saturation guard
  localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

  // Running statistics of the window in progress
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [LEVEL_W-1:0] min;
    logic [LEVEL_W-1:0] max;
  } window_stats_t;

endpackage

`default_nettype wire

FILE: rtl/lbtm_trim_mean.sv
// ----------------------------------------------------------------------------
// lbtm_trim_mean
// Trimmed mean of a finished window: (sum - min - max) / (WINDOW - 2),
// truncated, with the constant divide done as a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module lbtm_trim_mean #(
  parameter int WINDOW = 5
) (
  input  lbtm_pkg::window_stats_t       stats,
  output logic [lbtm_pkg::LEVEL_W-1:0]  mean
);
  import lbtm_pkg::*;

  // Divisor is at most 14, so four guard bits past the sum width make the
  // rounded-up reciprocal exact for every 16-bit numerator.
  localparam int DIV    = WINDOW - 2;
  localparam int SHIFT  = SUM_W + 4;
  localparam int RECIP  = ((1 << SHIFT) + DIV - 1) / DIV;
  localparam int PROD_W = SUM_W + SHIFT + 1;

  logic [LEVEL_W:0]   trim;
  logic [SUM_W-1:0]   rest;
  logic [PROD_W-1:0]  prod;

  // Drop the extremes, clamp at zero
  assign trim = {1'b0, stats.min} + {1'b0, stats.max};
  assign rest = (stats.sum >= SUM_W'(trim)) ? (stats.sum - SUM_W'(trim)) : '0;

  // Divide by multiplying with the reciprocal and keeping the high bits
  assign prod = PROD_W'(rest) * PROD_W'(RECIP);
  assign mean = prod[SHIFT +: LEVEL_W];

endmodule

`default_nettype wire

FILE: rtl/low_battery_trimmed_mean_monitor.sv
// ----------------------------------------------------------------------------
// low_battery_trimmed_mean_monitor
// Path: an accepted sample's word goes through stage one, then the result register.
// Throughput: one sample per cycle unless result_stall holds the pipeline.
// Reset: synchronous; clears window, low count and pipeline, reloads registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "low_battery_trimmed_mean_monitor_defines.svh"

module low_battery_trimmed_mean_monitor #(
  parameter int WINDOW = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  // Sample channel
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic [lbtm_pkg::LEVEL_W-1:0]     sample,
  // Result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             window_done,
  output logic [lbtm_pkg::LEVEL_W-1:0]     filtered_level,
  output logic                             below_threshold,
  output logic                             shutdown_request,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [lbtm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbtm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lbtm_pkg::*;

  localparam logic [POS_W-1:0] WIN_LAST = POS_W'(WINDOW - 1);

  // Configuration registers
  logic [LEVEL_W-1:0] low_threshold;
  logic [LIMIT_W-1:0] retry_limit;

  // Window accumulators
  window_stats_t      stats;
  window_stats_t      stats_next;
  logic [POS_W-1:0]   position;

  // Stage one: sample folded into the window
  logic               s1_valid;
  logic               s1_done;

  // Low-window counter
  logic [CNT_W-1:0]   low_count;
  logic [CNT_W-1:0]   low_count_inc;

  logic               accept;
  logic               s2_ready;
  logic [LEVEL_W-1:0] mean;
  logic               below;
  logic               over;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold <= RESET_THRESHOLD;
      retry_limit   <= RESET_RETRY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_THRESHOLD: low_threshold <= cfg_data[LEVEL_W-1:0];
        REG_RETRY_LIMIT:   retry_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage two moves when the result register is free or taken
  assign s2_ready     = !result_valid || !result_stall;
  assign sample_stall = s1_valid && !s2_ready;
  assign accept       = sample_valid && !sample_stall;

  // Load on the first sample of a window, accumulate otherwise
  always_comb begin
    if (position == '0) begin
      stats_next.sum = SUM_W'(sample);
      stats_next.min = sample;
      stats_next.max = sample;
    end else begin
      stats_next.sum = stats.sum + SUM_W'(sample);
      stats_next.min = (sample < stats.min) ? sample : stats.min;
      stats_next.max = (sample > stats.max) ? sample : stats.max;
    end
  end

  // Advance window accumulators and position
  always_ff @(posedge clk) begin
    if (rst) begin
      stats    <= '0;
      position <= '0;
    end else if (accept) begin
      stats    <= stats_next;
      position <= (position == WIN_LAST) ? '0 : position + POS_W'(1);
    end
  end

  // Stage one holds the word until stage two takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s2_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_done <= (position == WIN_LAST);
    end
  end

  // Trimmed mean of the window held in the accumulators
  lbtm_trim_mean #(
    .WINDOW (WINDOW)
  ) u_trim_mean (
    .stats (stats),
    .mean  (mean)
  );

  // Compare and count low windows in a row
  assign below         = (mean < low_threshold);
  assign low_count_inc = (low_count != CNT_MAX) ? low_count + CNT_W'(1) : low_count;
  assign over          = (low_count_inc > CNT_W'(retry_limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      low_count <= '0;
    end else if (s2_ready && s1_valid && s1_done) begin
      if (below && !over) begin
        low_count <= low_count_inc;
      end else begin
        low_count <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_ready) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      window_done      <= s1_done;
      filtered_level   <= s1_done ? mean : '0;
      below_threshold  <= s1_done && below;
      shutdown_request <= s1_done && below && over;
    end
  end

  // Checks
  `LBTM_ASSERT_IMPL(a_shut_needs_low, result_valid && shutdown_request,
    below_threshold && window_done, "shutdown without a low finished window")
  `LBTM_ASSERT_IMPL(a_idle_fields_zero, result_valid && !window_done,
    (filtered_level == '0) && !below_threshold, "fields set on an unfinished window")
  `LBTM_ASSERT_IMPL(a_position_range, 1'b1, position <= WIN_LAST,
    "window position past the last sample")
  `LBTM_ASSERT_IMPL(a_stall_only_full, sample_stall,
    s1_valid && result_valid && result_stall, "sample stalled with room in the pipeline")

endmodule

`default_nettype wire
